@@ hw/rtl/slfr_pkg.sv @@
// shared types, constants and codes of the scaled table lookup block
package slfr_pkg;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int LEN_W = 9;
	localparam int FACTOR_W = 31;
	localparam int ENTRY_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int PROD_W = LEN_W + FACTOR_W;

	// defaults
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int FRACTION_BITS = 16;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1 << FRACTION_BITS);
	localparam logic [LEN_W-1:0] LENGTH_RESET = LEN_W'(1);

	// item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LENGTH  = 3'd0,
		REG_FACTOR  = 3'd1,
		REG_OFFSET  = 3'd2,
		REG_INTERP  = 3'd3,
		REG_REVERSE = 3'd4
	} cfg_reg_e;

	// channel payloads
	typedef struct packed {
		logic                      cmd;
		logic [ENTRY_W-1:0]        entry_index;
		logic signed [VALUE_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value_out;
		logic                      clamped;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [VALUE_W-1:0]   wdata;
	} cfg_t;

	// table read address sources
	typedef enum logic [2:0] {
		ADDR_ZERO,
		ADDR_LAST,
		ADDR_IDX,
		ADDR_IDX1,
		ADDR_SCAN
	} addr_sel_e;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_SUB,
		OP_CLAMP,
		OP_DIV,
		OP_IDX,
		OP_LDA,
		OP_MUL_F,
		OP_RES_MEM,
		OP_RES_INT,
		OP_RINIT,
		OP_R0,
		OP_SCAN,
		OP_BASE,
		OP_RADD,
		OP_RSUM,
		OP_OUT
	} dp_op_e;

	typedef struct packed {
		logic      take;
		dp_op_e    op;
		addr_sel_e addr_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic req_query;
		logic reverse;
		logic interp;
		logic d_neg;
		logic d_gt;
		logic md_done;
		logic idx_at_last;
		logic x_le_rd;
		logic k_end;
		logic last_zero;
		logic clamp;
		logic out_free;
	} dp_status_t;

endpackage

@@ hw/rtl/slfr_stream_if.sv @@
// valid/ready channel carrying one payload type
interface slfr_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/slfr_muldiv.sv @@
// iterative floor(a*b/c) unit with remainder, for b <= c, a doubling step and an add step per bit of a
module slfr_muldiv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	output logic        done,
	output logic [31:0] q,
	output logic [31:0] r
);

	logic        busy_q;
	logic        phase_q;
	logic [4:0]  cnt_q;
	logic        done_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [31:0] c_q;
	logic [31:0] q_q;
	logic [31:0] r_q;
	logic [32:0] dbl;
	logic [32:0] sum;

	assign dbl = {r_q, 1'b0};
	assign sum = {1'b0, r_q} + {1'b0, b_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				phase_q <= 1'b0;
				cnt_q <= 5'd31;
				if (b >= c) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					if (cnt_q == 5'd0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
			end
		end
	end

	// quotient and remainder: double mod c, then add b mod c when the bit is set
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			c_q <= c;
			r_q <= '0;
			q_q <= (b >= c) ? a : 32'd0;
		end else if (busy_q) begin
			if (!phase_q) begin
				if (dbl >= {1'b0, c_q}) begin
					r_q <= 32'(dbl - {1'b0, c_q});
					q_q <= {q_q[30:0], 1'b1};
				end else begin
					r_q <= dbl[31:0];
					q_q <= {q_q[30:0], 1'b0};
				end
			end else if (a_q[cnt_q]) begin
				if (sum >= {1'b0, c_q}) begin
					r_q <= 32'(sum - {1'b0, c_q});
					q_q <= q_q + 32'd1;
				end else begin
					r_q <= sum[31:0];
				end
			end
		end
	end

	assign done = done_q;
	assign q = q_q;
	assign r = r_q;

endmodule

@@ hw/rtl/slfr_datapath.sv @@
// configuration, table memory, arithmetic and output register
module slfr_datapath #(
	parameter int TABLE_DEPTH = slfr_pkg::TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	slfr_stream_if.sink          req,
	slfr_stream_if.source        rsp,
	slfr_stream_if.sink          cfg,
	input  slfr_pkg::dp_cmd_t    cmd,
	output slfr_pkg::dp_status_t st
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int LW = slfr_pkg::LEN_W;
	localparam int FW = slfr_pkg::FACTOR_W;
	localparam int PW = slfr_pkg::PROD_W;
	localparam logic signed [41:0] SAT_HI = 42'sd2147483647;
	localparam logic signed [41:0] SAT_LO = -42'sd2147483648;

	// configuration registers
	logic [LW-1:0]      len_q;
	logic [FW-1:0]      factor_q;
	logic signed [31:0] offset_q;
	logic               interp_q;
	logic               reverse_q;

	// derived configuration
	logic [LW-1:0] last_c;
	logic [FW-1:0] feff_c;
	logic [LW-1:0] last_q;
	logic [FW-1:0] feff_q;
	logic [PW-1:0] lastf_q;

	// table
	logic signed [31:0] mem [TABLE_DEPTH];
	logic signed [31:0] rd_q;
	logic [LW-1:0]      rd_idx;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic               accept;

	// working registers
	logic signed [31:0] x_q;
	logic signed [32:0] d_q;
	logic [LW-1:0]      idx_q;
	logic [31:0]        frac_q;
	logic signed [31:0] a_q;
	logic               neg_q;
	logic signed [31:0] prev_q;
	logic [LW-1:0]      k_q;
	logic [LW-1:0]      e_q;
	logic [31:0]        dl_q;
	logic [31:0]        dh_q;
	logic [PW-1:0]      ef_q;
	logic [31:0]        add_q;
	logic signed [31:0] res_q;
	logic               clamp_q;

	// output register
	logic               rsp_valid_q;
	slfr_pkg::rsp_t     rsp_data_q;

	// multiply-divide unit
	logic        md_start;
	logic [31:0] md_a;
	logic [31:0] md_b;
	logic [31:0] md_c;
	logic        md_done;
	logic [31:0] md_q;
	logic [31:0] md_r;

	// combinational helpers
	logic               x_le_rd;
	logic               x_lt_rd;
	logic signed [32:0] diff_c;
	logic [31:0]        mag_c;
	logic               rnd_c;
	logic [32:0]        qn_c;
	logic signed [32:0] int_c;
	logic signed [41:0] rsum_c;

	assign cfg.ready = 1'b1;
	assign accept = req.valid && cmd.take;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= slfr_pkg::LENGTH_RESET;
			factor_q <= slfr_pkg::FACTOR_RESET;
			offset_q <= '0;
			interp_q <= 1'b0;
			reverse_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				slfr_pkg::REG_LENGTH:  len_q <= cfg.data.wdata[LW-1:0];
				slfr_pkg::REG_FACTOR:  factor_q <= cfg.data.wdata[FW-1:0];
				slfr_pkg::REG_OFFSET:  offset_q <= cfg.data.wdata;
				slfr_pkg::REG_INTERP:  interp_q <= cfg.data.wdata[0];
				slfr_pkg::REG_REVERSE: reverse_q <= cfg.data.wdata[0];
				default: ;
			endcase
		end
	end

	// effective length and factor
	always_comb begin
		if (len_q == '0) begin
			last_c = '0;
		end else if (32'(len_q) > TABLE_DEPTH) begin
			last_c = LW'(TABLE_DEPTH - 1);
		end else begin
			last_c = len_q - LW'(1);
		end
		feff_c = (factor_q == '0) ? FW'(1) : factor_q;
	end

	always_ff @(posedge clk) begin
		last_q <= last_c;
		feff_q <= feff_c;
		lastf_q <= PW'(last_c) * PW'(feff_c);
	end

	// table write and registered read
	assign wr_en = accept && (req.data.cmd == slfr_pkg::CMD_WRITE) &&
		(32'(req.data.entry_index) < TABLE_DEPTH);

	always_comb begin
		unique case (cmd.addr_sel)
			slfr_pkg::ADDR_ZERO: rd_idx = '0;
			slfr_pkg::ADDR_LAST: rd_idx = last_q;
			slfr_pkg::ADDR_IDX:  rd_idx = idx_q;
			slfr_pkg::ADDR_IDX1: rd_idx = idx_q + LW'(1);
			slfr_pkg::ADDR_SCAN: rd_idx = k_q;
			default:             rd_idx = '0;
		endcase
	end

	assign rd_addr = AW'(rd_idx);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(req.data.entry_index)] <= req.data.value_in;
		end
		rd_q <= mem[rd_addr];
	end

	// compare and arithmetic helpers
	assign x_le_rd = x_q <= rd_q;
	assign x_lt_rd = x_q < rd_q;
	assign diff_c = {rd_q[31], rd_q} - {a_q[31], a_q};
	assign mag_c = diff_c[32] ? 32'(-diff_c) : diff_c[31:0];
	assign rnd_c = {md_r, 1'b0} >= {2'b00, feff_q};
	assign qn_c = {1'b0, md_q} + 33'(rnd_c);
	assign int_c = neg_q ? ({a_q[31], a_q} - signed'({1'b0, md_q}))
		: ({a_q[31], a_q} + signed'({1'b0, md_q}));
	assign rsum_c = signed'({2'b00, ef_q}) + signed'({10'd0, add_q}) + 42'(offset_q);

	// multiply-divide operand selection
	assign md_start = (cmd.op == slfr_pkg::OP_DIV) || (cmd.op == slfr_pkg::OP_MUL_F) ||
		((cmd.op == slfr_pkg::OP_BASE) && !clamp_q && interp_q);

	always_comb begin
		unique case (cmd.op)
			slfr_pkg::OP_DIV: begin
				md_a = d_q[31:0];
				md_b = 32'd1;
				md_c = {1'b0, feff_q};
			end
			slfr_pkg::OP_MUL_F: begin
				md_a = mag_c;
				md_b = frac_q;
				md_c = {1'b0, feff_q};
			end
			default: begin
				md_a = {1'b0, feff_q};
				md_b = dl_q;
				md_c = dl_q + dh_q;
			end
		endcase
	end

	slfr_muldiv u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (md_start),
		.a     (md_a),
		.b     (md_b),
		.c     (md_c),
		.done  (md_done),
		.q     (md_q),
		.r     (md_r)
	);

	// clamp flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_q <= 1'b0;
		end else if (accept) begin
			clamp_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				slfr_pkg::OP_CLAMP: clamp_q <= 1'b1;
				slfr_pkg::OP_R0: begin
					if (x_le_rd) begin
						clamp_q <= x_lt_rd;
					end else if (last_q == '0) begin
						clamp_q <= 1'b1;
					end
				end
				slfr_pkg::OP_SCAN: begin
					if (!x_le_rd && (k_q - LW'(1) == last_q)) begin
						clamp_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= req.data.value_in;
		end
		unique case (cmd.op)
			slfr_pkg::OP_SUB: d_q <= {x_q[31], x_q} - {offset_q[31], offset_q};
			slfr_pkg::OP_IDX: begin
				frac_q <= md_r;
				if (interp_q) begin
					idx_q <= md_q[LW-1:0];
				end else if (qn_c > 33'(last_q)) begin
					idx_q <= last_q;
				end else begin
					idx_q <= qn_c[LW-1:0];
				end
			end
			slfr_pkg::OP_LDA: a_q <= rd_q;
			slfr_pkg::OP_MUL_F: neg_q <= diff_c[32];
			slfr_pkg::OP_RES_MEM: res_q <= rd_q;
			slfr_pkg::OP_RES_INT: res_q <= int_c[31:0];
			slfr_pkg::OP_RINIT: k_q <= LW'(1);
			slfr_pkg::OP_R0: begin
				if (x_le_rd) begin
					res_q <= offset_q;
				end else begin
					prev_q <= rd_q;
					k_q <= k_q + LW'(1);
					e_q <= last_q;
				end
			end
			slfr_pkg::OP_SCAN: begin
				if (x_le_rd) begin
					e_q <= k_q - LW'(2);
					dl_q <= 32'({x_q[31], x_q} - {prev_q[31], prev_q});
					dh_q <= 32'({rd_q[31], rd_q} - {x_q[31], x_q});
				end else if (k_q - LW'(1) == last_q) begin
					e_q <= last_q;
				end else begin
					prev_q <= rd_q;
					k_q <= k_q + LW'(1);
				end
			end
			slfr_pkg::OP_BASE: begin
				ef_q <= PW'(e_q) * PW'(feff_q);
				add_q <= (!clamp_q && (dl_q >= dh_q)) ? {1'b0, feff_q} : 32'd0;
			end
			slfr_pkg::OP_RADD: add_q <= md_q;
			slfr_pkg::OP_RSUM: begin
				priority if (rsum_c > SAT_HI) begin
					res_q <= 32'sh7fffffff;
				end else if (rsum_c < SAT_LO) begin
					res_q <= 32'sh80000000;
				end else begin
					res_q <= rsum_c[31:0];
				end
			end
			default: ;
		endcase
	end

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.op == slfr_pkg::OP_OUT) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == slfr_pkg::OP_OUT) begin
			rsp_data_q.value_out <= res_q;
			rsp_data_q.clamped <= clamp_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;
	assign req.ready = cmd.take;

	// status to the controller
	always_comb begin
		st.req_valid = req.valid;
		st.req_query = req.data.cmd == slfr_pkg::CMD_QUERY;
		st.reverse = reverse_q;
		st.interp = interp_q;
		st.d_neg = d_q[32];
		st.d_gt = !d_q[32] && ({7'd0, d_q} > lastf_q);
		st.md_done = md_done;
		st.idx_at_last = idx_q >= last_q;
		st.x_le_rd = x_le_rd;
		st.k_end = (k_q - LW'(1)) == last_q;
		st.last_zero = last_q == '0;
		st.clamp = clamp_q;
		st.out_free = !rsp_valid_q || rsp.ready;
	end

endmodule

@@ hw/rtl/slfr_ctrl.sv @@
// sequencer for forward lookup and reverse search
module slfr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slfr_pkg::dp_status_t st,
	output slfr_pkg::dp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_F_SUB,
		S_F_CHK,
		S_F_RES,
		S_F_DIV,
		S_F_RD,
		S_F_RA,
		S_F_RB,
		S_F_MUL,
		S_R_RD0,
		S_R_CMP0,
		S_R_SCAN,
		S_R_BASE,
		S_R_MUL,
		S_R_SUM,
		S_OUT
	} state_t;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd.take = 1'b0;
		cmd.op = slfr_pkg::OP_NONE;
		cmd.addr_sel = slfr_pkg::ADDR_ZERO;
		unique case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (st.req_valid && st.req_query) begin
					state_d = st.reverse ? S_R_RD0 : S_F_SUB;
				end
			end
			S_F_SUB: begin
				cmd.op = slfr_pkg::OP_SUB;
				state_d = S_F_CHK;
			end
			S_F_CHK: begin
				priority if (st.d_neg) begin
					cmd.op = slfr_pkg::OP_CLAMP;
					cmd.addr_sel = slfr_pkg::ADDR_ZERO;
					state_d = S_F_RES;
				end else if (st.d_gt) begin
					cmd.op = slfr_pkg::OP_CLAMP;
					cmd.addr_sel = slfr_pkg::ADDR_LAST;
					state_d = S_F_RES;
				end else begin
					cmd.op = slfr_pkg::OP_DIV;
					state_d = S_F_DIV;
				end
			end
			S_F_RES: begin
				cmd.op = slfr_pkg::OP_RES_MEM;
				state_d = S_OUT;
			end
			S_F_DIV: begin
				if (st.md_done) begin
					cmd.op = slfr_pkg::OP_IDX;
					state_d = S_F_RD;
				end
			end
			S_F_RD: begin
				cmd.addr_sel = slfr_pkg::ADDR_IDX;
				state_d = (!st.interp || st.idx_at_last) ? S_F_RES : S_F_RA;
			end
			S_F_RA: begin
				cmd.op = slfr_pkg::OP_LDA;
				cmd.addr_sel = slfr_pkg::ADDR_IDX1;
				state_d = S_F_RB;
			end
			S_F_RB: begin
				cmd.op = slfr_pkg::OP_MUL_F;
				state_d = S_F_MUL;
			end
			S_F_MUL: begin
				if (st.md_done) begin
					cmd.op = slfr_pkg::OP_RES_INT;
					state_d = S_OUT;
				end
			end
			S_R_RD0: begin
				cmd.op = slfr_pkg::OP_RINIT;
				cmd.addr_sel = slfr_pkg::ADDR_ZERO;
				state_d = S_R_CMP0;
			end
			S_R_CMP0: begin
				cmd.op = slfr_pkg::OP_R0;
				cmd.addr_sel = slfr_pkg::ADDR_SCAN;
				priority if (st.x_le_rd) begin
					state_d = S_OUT;
				end else if (st.last_zero) begin
					state_d = S_R_BASE;
				end else begin
					state_d = S_R_SCAN;
				end
			end
			// one entry per cycle, next read already in flight
			S_R_SCAN: begin
				cmd.op = slfr_pkg::OP_SCAN;
				cmd.addr_sel = slfr_pkg::ADDR_SCAN;
				if (st.x_le_rd || st.k_end) begin
					state_d = S_R_BASE;
				end
			end
			S_R_BASE: begin
				cmd.op = slfr_pkg::OP_BASE;
				state_d = (st.clamp || !st.interp) ? S_R_SUM : S_R_MUL;
			end
			S_R_MUL: begin
				if (st.md_done) begin
					cmd.op = slfr_pkg::OP_RADD;
					state_d = S_R_SUM;
				end
			end
			S_R_SUM: begin
				cmd.op = slfr_pkg::OP_RSUM;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.op = slfr_pkg::OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/scaled_lut_forward_reverse.sv @@
// top level: table lookup with interpolation, forward and reverse
//
//   channel  dir   beat                                   accepted when
//   req      in    cmd, entry_index, value_in             req.valid & req.ready
//   rsp      out   value_out, clamped                     rsp.valid & rsp.ready
//   cfg      in    index, wdata                           cfg.valid & cfg.ready
//
// a write beat leaves the block ready again at once
// a forward query that is not clamped runs the shared bit-serial
// multiply-divide unit once, and once more to interpolate between two entries
// a reverse query reads one table entry per cycle in the scan, and runs the
// multiply-divide unit only when interpolating and not clamped
// no clearing pass after reset; cfg is always ready
// a finished result waits in the output register while the next beat is accepted
module scaled_lut_forward_reverse #(
	parameter int TABLE_DEPTH = slfr_pkg::TABLE_DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	slfr_stream_if.sink   req,
	slfr_stream_if.source rsp,
	slfr_stream_if.sink   cfg
);

	slfr_pkg::dp_cmd_t    cmd;
	slfr_pkg::dp_status_t st;

	// sequencer
	slfr_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.st    (st),
		.cmd   (cmd)
	);

	// datapath with table and output register
	slfr_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_datapath (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg),
		.cmd   (cmd),
		.st    (st)
	);

endmodule

@@ hw/rtl/slfr_checker.sv @@
// port-level checks of the table lookup block and their binding
module slfr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           req_cmd,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input slfr_pkg::rsp_t rsp_data
);

	// a stalled result beat stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result payload changed while stalled");

	// a query beat occupies the block in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == slfr_pkg::CMD_QUERY) |=> !req_ready)
		else $error("ready while a query is at work");

	// a write beat leaves the block ready for the next beat
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == slfr_pkg::CMD_WRITE) |=> req_ready)
		else $error("write beat stalled the block");

endmodule

bind scaled_lut_forward_reverse slfr_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.req_cmd  (req.data.cmd),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);

@@ tb/tb_scaled_lut_forward_reverse.sv @@
// testbench of the scaled table lookup block: random and directed queries checked in order
module tb_scaled_lut_forward_reverse;

	// expected results in arrival order, with table and register copies
	class lookup_scoreboard;
		logic signed [31:0] entries [256];
		logic [8:0] len_reg;
		logic [30:0] factor_reg;
		logic signed [31:0] offset_reg;
		bit interp_reg;
		bit reverse_reg;
		slfr_pkg::rsp_t pending [$];
		int errors;
		int checked;

		function new();
			len_reg = slfr_pkg::LENGTH_RESET;
			factor_reg = slfr_pkg::FACTOR_RESET;
			offset_reg = 0;
			interp_reg = 0;
			reverse_reg = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_reg(slfr_pkg::cfg_reg_e idx, logic [31:0] wdata);
			case (idx)
				slfr_pkg::REG_LENGTH: len_reg = wdata[8:0];
				slfr_pkg::REG_FACTOR: factor_reg = wdata[30:0];
				slfr_pkg::REG_OFFSET: offset_reg = wdata;
				slfr_pkg::REG_INTERP: interp_reg = wdata[0];
				slfr_pkg::REG_REVERSE: reverse_reg = wdata[0];
				default: ;
			endcase
		endfunction

		// floor(a*b/c) with wide intermediate
		function longint unsigned scale_div(longint unsigned a, longint unsigned b,
				longint unsigned c);
			logic [127:0] p;
			p = 128'(a) * 128'(b);
			return 64'(p / 128'(c));
		endfunction

		function longint sat(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint forward_map(longint x, longint unsigned n, longint unsigned f,
				output bit clamp);
			longint d, a, b, diff;
			longint unsigned ud, idx, frac, mag, term;
			clamp = 0;
			d = x - longint'(offset_reg);
			if (d < 0) begin
				clamp = 1;
				return entries[0];
			end
			ud = d;
			if (ud > (n - 1) * f) begin
				clamp = 1;
				return entries[n-1];
			end
			if (!interp_reg) begin
				idx = (2 * ud + f) / (2 * f);
				if (idx > n - 1) idx = n - 1;
				return entries[idx];
			end
			idx = ud / f;
			frac = ud % f;
			if (idx >= n - 1) return entries[n-1];
			a = entries[idx];
			b = entries[idx+1];
			diff = b - a;
			mag = diff < 0 ? -diff : diff;
			term = scale_div(mag, frac, f);
			return diff < 0 ? a - longint'(term) : a + longint'(term);
		endfunction

		function longint reverse_map(longint x, longint unsigned n, longint unsigned f,
				output bit clamp);
			longint unsigned e, base;
			longint dl, dh;
			clamp = 0;
			if (x <= entries[0]) begin
				if (x < entries[0]) clamp = 1;
				return sat(offset_reg);
			end
			for (e = 0; e + 1 < n; e++)
				if (x > entries[e] && x <= entries[e+1]) break;
			if (e + 1 >= n) begin
				clamp = 1;
				return sat(longint'((n - 1) * f) + offset_reg);
			end
			dl = x - entries[e];
			dh = entries[e+1] - x;
			base = e * f;
			if (!interp_reg) begin
				if (!(dl < dh)) base += f;
			end else begin
				base += scale_div(dl, f, dl + dh);
			end
			return sat(longint'(base) + offset_reg);
		endfunction

		// note an accepted request beat
		function void note_request(slfr_pkg::req_t r);
			longint unsigned n, f;
			longint v;
			bit c;
			slfr_pkg::rsp_t e;
			if (r.cmd == slfr_pkg::CMD_WRITE) begin
				entries[r.entry_index] = r.value_in;
				return;
			end
			n = len_reg == 0 ? 1 : (len_reg > 256 ? 256 : len_reg);
			f = factor_reg == 0 ? 1 : factor_reg;
			if (reverse_reg) v = reverse_map(r.value_in, n, f, c);
			else v = forward_map(r.value_in, n, f, c);
			e.value_out = v[31:0];
			e.clamped = c;
			pending.push_back(e);
		endfunction

		// compare a response beat with the oldest expectation
		function void check_response(slfr_pkg::rsp_t got);
			slfr_pkg::rsp_t e;
			if (pending.size() == 0) begin
				$display("%0t unexpected response value_out=%h clamped=%b", $time,
					got.value_out, got.clamped);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (got.value_out !== e.value_out) begin
				$display("%0t value_out mismatch: expected %h actual %h", $time,
					e.value_out, got.value_out);
				errors++;
			end
			if (got.clamped !== e.clamped) begin
				$display("%0t clamped mismatch: expected %b actual %b", $time,
					e.clamped, got.clamped);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	slfr_stream_if #(.T(slfr_pkg::req_t)) req ();
	slfr_stream_if #(.T(slfr_pkg::rsp_t)) rsp ();
	slfr_stream_if #(.T(slfr_pkg::cfg_t)) cfg ();

	scaled_lut_forward_reverse DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.cfg(cfg)
	);

	lookup_scoreboard lut_sb;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	longint cycle_count;
	int query_count;

	// clock
	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > 3000000) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// response side: random stalls and long hold-offs
	initial begin
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				lut_sb.check_response(rsp.data);
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				rsp.ready <= 0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// one request beat, valid stays up until the next beat, an idle gap or a drain
	task automatic send_request(logic cmd, logic [7:0] idx, logic signed [31:0] val);
		slfr_pkg::req_t r;
		r.cmd = cmd;
		r.entry_index = idx;
		r.value_in = val;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 0;
			@(posedge clk);
		end
		req.valid <= 1;
		req.data <= r;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		lut_sb.note_request(r);
		if (cmd == slfr_pkg::CMD_QUERY) query_count++;
	endtask

	task automatic drain();
		req.valid <= 0;
		while (lut_sb.pending.size() != 0) @(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	// register write while idle
	task automatic write_reg(slfr_pkg::cfg_reg_e idx, logic [31:0] wdata);
		slfr_pkg::cfg_t c;
		c.index = idx;
		c.wdata = wdata;
		cfg.valid <= 1;
		cfg.data <= c;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		lut_sb.set_reg(idx, wdata);
	endtask

	task automatic setup(int n, logic [30:0] f, logic [31:0] off, bit interp, bit rev);
		write_reg(slfr_pkg::REG_LENGTH, 32'(n));
		write_reg(slfr_pkg::REG_FACTOR, 32'(f));
		write_reg(slfr_pkg::REG_OFFSET, off);
		write_reg(slfr_pkg::REG_INTERP, 32'(interp));
		write_reg(slfr_pkg::REG_REVERSE, 32'(rev));
		cfg.valid <= 0;
	endtask

	// fill entries 0..n-1, increasing with random steps
	task automatic fill_increasing(int n, int step_max);
		logic signed [31:0] v;
		v = -$signed(32'($urandom_range(1 << 20)));
		for (int i = 0; i < n; i++) begin
			send_request(slfr_pkg::CMD_WRITE, 8'(i), v);
			v = v + $urandom_range(step_max, 1);
		end
	endtask

	function automatic logic signed [31:0] pick_query(int n);
		longint unsigned span;
		longint base;
		if ($urandom_range(9) == 0) return $urandom;
		if (lut_sb.reverse_reg) begin
			base = lut_sb.entries[0];
			span = lut_sb.entries[n-1] - base;
			return 32'(base - 100 + longint'($urandom_range(32'(span + 200))));
		end
		span = longint'(n) * lut_sb.factor_reg;
		return 32'(longint'(lut_sb.offset_reg) - 1000 +
			longint'($urandom_range(32'(span > 64'hFFFF0000 ? 64'hFFFF0000 : span + 2000))));
	endfunction

	initial begin
		int n;
		lut_sb = new();
		arst_n = 0;
		req.valid = 0;
		req.data = '0;
		cfg.valid = 0;
		cfg.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		query_count = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reset length of one, extremes of the query value
		send_request(slfr_pkg::CMD_WRITE, 0, 32'sh7FFFFFFF);
		send_request(slfr_pkg::CMD_QUERY, 0, 32'sh80000000);
		send_request(slfr_pkg::CMD_QUERY, 0, 0);
		send_request(slfr_pkg::CMD_QUERY, 0, 32'sh7FFFFFFF);
		drain();
		// full table, unit factor: exact last position and beyond
		setup(256, 1, 0, 0, 0);
		fill_increasing(256, 1 << 16);
		send_request(slfr_pkg::CMD_WRITE, 255, 32'sh7FFFFFFF);
		send_request(slfr_pkg::CMD_QUERY, 0, 255);
		send_request(slfr_pkg::CMD_QUERY, 0, 256);
		send_request(slfr_pkg::CMD_QUERY, 0, -1);
		drain();
		// max factor, min offset, interpolating
		setup(2, 31'h7FFFFFFF, 32'h80000000, 1, 0);
		send_request(slfr_pkg::CMD_WRITE, 1, 32'sh80000000);
		send_request(slfr_pkg::CMD_QUERY, 0, 32'sh7FFFFFFE);
		send_request(slfr_pkg::CMD_QUERY, 0, 32'sh7FFFFFFF);
		send_request(slfr_pkg::CMD_QUERY, 0, 0);
		drain();
		// reverse: below, equal to first, ties, above, saturation
		setup(3, 31'h7FFFFFFF, 32'h7FFFFFFF, 0, 1);
		send_request(slfr_pkg::CMD_WRITE, 0, 0);
		send_request(slfr_pkg::CMD_WRITE, 1, 10);
		send_request(slfr_pkg::CMD_WRITE, 2, 20);
		send_request(slfr_pkg::CMD_QUERY, 0, -1);
		send_request(slfr_pkg::CMD_QUERY, 0, 0);
		send_request(slfr_pkg::CMD_QUERY, 0, 5);
		send_request(slfr_pkg::CMD_QUERY, 0, 21);
		drain();
		// random phases over mode and idling combinations
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 48; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 48; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			n = (ph == 15) ? 256 : $urandom_range(12, 1);
			setup(n, (ph % 3 == 0) ? 31'($urandom_range(1 << 20, 1)) :
				31'($urandom_range(1 << 24, 1)), $urandom, ph[0], ph[1]);
			fill_increasing(n, ph[2] ? 1 << 20 : 1 << 12);
			if (ph == 5) hold_off_cycles = 2000;
			for (int k = 0; k < 8; k++) begin
				if ($urandom_range(9) == 0)
					send_request(slfr_pkg::CMD_WRITE, 8'($urandom_range(n - 1)),
						lut_sb.entries[$urandom_range(n - 1)]);
				else
					send_request(slfr_pkg::CMD_QUERY, 8'($urandom), pick_query(n));
			end
			drain();
		end

		$display("covered %0d queries over 20 settings, forward and reverse, nearest and linear",
			query_count);
		if (lut_sb.errors == 0 && lut_sb.pending.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
